// ----- rtl/core/qbls_pkg.sv -----
`timescale 1ns / 1ps

package qbls_pkg;

	// Input kinds, carried on the input tuser bit.
	localparam logic OP_START = 1'b0;
	localparam logic OP_NEXT  = 1'b1;

	typedef logic [1:0] status_t;

	localparam status_t ST_SEG    = 2'd0;
	localparam status_t ST_ACCEPT = 2'd1;
	localparam status_t ST_REJECT = 2'd2;
	localparam status_t ST_NONE   = 2'd3;

endpackage

// ----- rtl/core/qbls_front.sv -----
`timescale 1ns / 1ps

module qbls_front #(
	parameter int CW = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_op,
	input  logic [6*CW-1:0]      in_pts,
	output logic                 out_valid,
	input  logic                 out_ready,
	// {op, ax, ay, bx, by, x0, y0, x1, y1} from the top bit down
	output logic [8*CW+4:0]      out_entry
);
	import qbls_pkg::*;

	localparam int DW = CW + 1;

	logic [CW-1:0] x0, y0, x1, y1, x2, y2;
	logic [DW-1:0] ax, ay, bx, by;
	logic          valid_s1;
	logic [8*CW+4:0] entry_s1;

	assign x0 = in_pts[0*CW +: CW];
	assign y0 = in_pts[1*CW +: CW];
	assign x1 = in_pts[2*CW +: CW];
	assign y1 = in_pts[3*CW +: CW];
	assign x2 = in_pts[4*CW +: CW];
	assign y2 = in_pts[5*CW +: CW];

	// The legs are formed here so that the back end starts with the squares.
	assign ax = {x1[CW-1], x1} - {x0[CW-1], x0};
	assign ay = {y1[CW-1], y1} - {y0[CW-1], y0};
	assign bx = {x2[CW-1], x2} - {x1[CW-1], x1};
	assign by = {y2[CW-1], y2} - {y1[CW-1], y1};

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			if (in_op == OP_START) begin
				entry_s1 <= {OP_START, ax, ay, bx, by, x0, y0, x1, y1};
			end else begin
				entry_s1 <= {OP_NEXT, {(8*CW+4){1'b0}}};
			end
		end
	end

endmodule

// ----- rtl/core/qbls_queue.sv -----
`timescale 1ns / 1ps

module qbls_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_pop,
	output logic [W-1:0] out_data
);

	logic [W-1:0] slot_q [2];
	logic         wr_q, rd_q;
	logic [1:0]   cnt_q;
	logic         push, pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = slot_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= in_data;
	end

endmodule

// ----- rtl/core/qbls_div.sv -----
`timescale 1ns / 1ps

module qbls_div #(
	parameter int N_W = 46,
	parameter int D_W = 29,
	parameter int Q_W = 18
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           done,
	output logic [Q_W-1:0] quo
);

	localparam int C_W = $clog2(N_W);

	logic [N_W-1:0] num_q;
	logic [D_W-1:0] den_q;
	logic [D_W-1:0] rem_q;
	logic [Q_W-1:0] quo_q;
	logic [C_W-1:0] cnt_q;
	logic           busy_q, done_q;
	logic [D_W:0]   rem_n;
	logic           fits;

	// Restoring division, one quotient bit per cycle; only the low quotient
	// bits are kept, the callers guarantee the quotient fits.
	assign rem_n = {rem_q, num_q[N_W-1]};
	assign fits  = rem_n >= {1'b0, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && cnt_q == C_W'(N_W - 1);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == C_W'(N_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[N_W-2:0], 1'b0};
			rem_q <= fits ? D_W'(rem_n - {1'b0, den_q}) : rem_n[D_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], fits};
			cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

// ----- rtl/core/qbls_back.sv -----
`timescale 1ns / 1ps

module qbls_back #(
	parameter int CW = 12,
	parameter int F  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  logic [8*CW+4:0]      q_entry,
	output logic                 out_valid,
	input  logic                 out_ready,
	output qbls_pkg::status_t    out_status,
	output logic [CW-1:0]        out_from_x,
	output logic [CW-1:0]        out_from_y,
	output logic [CW-1:0]        out_to_x,
	output logic [CW-1:0]        out_to_y,
	output logic [CW:0]          out_count,
	output logic                 out_last
);
	import qbls_pkg::*;

	localparam int DW   = CW + 1;
	localparam int SQ_W = 2 * CW + 2;
	localparam int R_W  = CW + F + 1;
	localparam int RM_W = R_W + 2;
	localparam int N_W  = 2 * F + CW + 2;
	localparam int Q_W  = F + 2;
	localparam int PT_W = CW + F + 2;
	localparam int D_W  = PT_W + 1;
	localparam int T_W  = DW + Q_W;
	localparam int HI_W = D_W - F;
	localparam int PH_W = HI_W + T_W;
	localparam int PL_W = F + T_W;
	localparam int AC_W = PH_W + 1;
	localparam int V_W  = AC_W + 2;
	localparam int IT_W = $clog2(R_W);

	localparam logic [2:0] DIV_INV = 3'd0;
	localparam logic [2:0] DIV_AX  = 3'd1;
	localparam logic [2:0] DIV_AY  = 3'd2;
	localparam logic [2:0] DIV_BX  = 3'd3;
	localparam logic [2:0] DIV_BY  = 3'd4;

	localparam logic [PL_W:0]  HALF_PL = (PL_W + 1)'(1) << (F - 1);
	localparam logic [V_W-1:0] HALF_V  = V_W'(1) << (F - 1);
	localparam logic [V_W-1:0] PMAX    = (V_W'(1) << (CW - 1)) - V_W'(1);
	localparam logic [V_W-1:0] NMAG    = V_W'(1) << (CW - 1);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SQ   = 9'b000000010,
		S_SUM  = 9'b000000100,
		S_ROOT = 9'b000001000,
		S_DGO  = 9'b000010000,
		S_DWT  = 9'b000100000,
		S_T    = 9'b001000000,
		S_MUL  = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t state_q;

	// Command fields from the queue
	logic          e_op;
	logic [DW-1:0] e_ax, e_ay, e_bx, e_by;
	logic [CW-1:0] e_x0, e_y0, e_x1, e_y1;

	logic [DW-1:0] leg_q [4];
	logic [CW-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [DW-1:0] lmag [4];
	logic [2*DW-1:0] sqr_q [4];
	logic [SQ_W-1:0] sa, sb, sq;

	logic [SQ_W-1:0] sqsh_q;
	logic [RM_W-1:0] rem_q, rem_n, trial;
	logic [R_W-1:0]  root_q;
	logic [IT_W-1:0] it_q;

	logic [2:0]      didx_q;
	logic            div_start, div_done;
	logic [N_W-1:0]  div_num;
	logic [Q_W-1:0]  div_quo;
	logic [DW-1:0]   dsel;
	logic            dneg;
	logic [PT_W-1:0] qstep;

	// Curve state
	logic [PT_W-1:0] apt_q [2];
	logic [PT_W-1:0] bpt_q [2];
	logic [PT_W-1:0] astep_q [2];
	logic [PT_W-1:0] bstep_q [2];
	logic [Q_W-1:0]  inv_q;
	logic [DW-1:0]   idx_q, total_q, idx_nx;
	logic [CW-1:0]   prev_q [2];
	logic            active_q;

	// Segment arithmetic
	logic [T_W-1:0]  t_q;
	logic [D_W-1:0]  dd [2];
	logic [D_W-1:0]  dmag [2];
	logic [PH_W-1:0] ph_q [2];
	logic [PL_W-1:0] pl_q [2];
	logic            neg_q [2];
	logic [PL_W:0]   plr [2];
	logic [AC_W-1:0] qv [2];
	logic [V_W-1:0]  vv [2], vmag [2], rv [2], nrv [2];
	logic [CW-1:0]   pt [2];

	// Pending result and output register
	logic            pend_q;
	status_t         res_status_q;
	logic [CW-1:0]   res_from_q [2];
	logic [CW-1:0]   res_to_q [2];
	logic [DW-1:0]   res_count_q;
	logic            res_last_q;
	logic            out_valid_q;
	status_t         out_status_q;
	logic [CW-1:0]   out_from_q [2];
	logic [CW-1:0]   out_to_q [2];
	logic [DW-1:0]   out_count_q;
	logic            out_last_q;
	logic            out_free, can_take;

	assign {e_op, e_ax, e_ay, e_bx, e_by, e_x0, e_y0, e_x1, e_y1} = q_entry;

	assign out_free = !out_valid_q || out_ready;
	assign can_take = state_q == S_IDLE && (!pend_q || out_free);
	assign q_pop    = can_take && q_valid;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			lmag[j] = leg_q[j][DW-1] ? DW'(~leg_q[j] + 1'b1) : leg_q[j];
		end
		sa = SQ_W'(sqr_q[0]) + SQ_W'(sqr_q[1]);
		sb = SQ_W'(sqr_q[2]) + SQ_W'(sqr_q[3]);
		sq = (sa > sb) ? sa : sb;
	end

	// One step of the bit-serial root, two radicand bits per step.
	assign rem_n = {rem_q[RM_W-3:0], sqsh_q[SQ_W-1 -: 2]};
	assign trial = {root_q, 2'b01};

	always_comb begin
		dsel = leg_q[0];
		unique case (didx_q)
			DIV_AX:  dsel = leg_q[0];
			DIV_AY:  dsel = leg_q[1];
			DIV_BX:  dsel = leg_q[2];
			DIV_BY:  dsel = leg_q[3];
			default: dsel = leg_q[0];
		endcase
		dneg = dsel[DW-1];
		if (didx_q == DIV_INV) begin
			div_num = (N_W'(1) << (2 * F)) + N_W'(root_q >> 1);
		end else begin
			div_num = (N_W'(dneg ? DW'(~dsel + 1'b1) : dsel) << F) + N_W'(root_q >> 1);
		end
		qstep = dneg ? PT_W'(~PT_W'(div_quo) + 1'b1) : PT_W'(div_quo);
	end

	assign div_start = state_q == S_DGO;

	qbls_div #(
		.N_W (N_W),
		.D_W (R_W),
		.Q_W (Q_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (root_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			dd[j]   = {bpt_q[j][PT_W-1], bpt_q[j]} - {apt_q[j][PT_W-1], apt_q[j]};
			dmag[j] = dd[j][D_W-1] ? D_W'(~dd[j] + 1'b1) : dd[j];
			plr[j]  = (PL_W + 1)'(pl_q[j]) + HALF_PL;
			qv[j]   = AC_W'(ph_q[j]) + AC_W'(plr[j][PL_W:F]);
			vv[j]   = {{(V_W - PT_W){apt_q[j][PT_W-1]}}, apt_q[j]}
			        + (neg_q[j] ? V_W'(~V_W'(qv[j]) + 1'b1) : V_W'(qv[j]));
			vmag[j] = vv[j][V_W-1] ? V_W'(~vv[j] + 1'b1) : vv[j];
			rv[j]   = (vmag[j] + HALF_V) >> F;
			nrv[j]  = ~rv[j] + 1'b1;
			if (!vv[j][V_W-1]) begin
				pt[j] = (rv[j] > PMAX) ? PMAX[CW-1:0] : rv[j][CW-1:0];
			end else begin
				pt[j] = (rv[j] > NMAG) ? NMAG[CW-1:0] : nrv[j][CW-1:0];
			end
		end
	end

	assign idx_nx = idx_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
			idx_q       <= '0;
			total_q     <= '0;
			inv_q       <= '0;
			for (int j = 0; j < 2; j++) begin
				apt_q[j]   <= '0;
				bpt_q[j]   <= '0;
				astep_q[j] <= '0;
				bstep_q[j] <= '0;
				prev_q[j]  <= '0;
			end
		end else begin
			if (can_take && pend_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					// A waiting result leaves once the output register is free.
					pend_q <= (pend_q && !can_take) ||
					          (q_pop && e_op == OP_NEXT && !active_q);
					if (q_pop) begin
						if (e_op == OP_START) begin
							state_q <= S_SQ;
						end else if (active_q) begin
							state_q <= S_T;
						end
					end
				end
				S_SQ: state_q <= S_SUM;
				S_SUM: begin
					if (sq == '0) begin
						active_q <= 1'b0;
						pend_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (it_q == IT_W'(R_W - 1)) state_q <= S_DGO;
				end
				S_DGO: state_q <= S_DWT;
				S_DWT: begin
					if (div_done) begin
						case (didx_q)
							DIV_INV: inv_q      <= div_quo;
							DIV_AX:  astep_q[0] <= qstep;
							DIV_AY:  astep_q[1] <= qstep;
							DIV_BX:  bstep_q[0] <= qstep;
							default: bstep_q[1] <= qstep;
						endcase
						if (didx_q == DIV_BY) begin
							apt_q[0]  <= {{(PT_W - CW - F){x0_q[CW-1]}}, x0_q, {F{1'b0}}};
							apt_q[1]  <= {{(PT_W - CW - F){y0_q[CW-1]}}, y0_q, {F{1'b0}}};
							bpt_q[0]  <= {{(PT_W - CW - F){x1_q[CW-1]}}, x1_q, {F{1'b0}}};
							bpt_q[1]  <= {{(PT_W - CW - F){y1_q[CW-1]}}, y1_q, {F{1'b0}}};
							prev_q[0] <= x0_q;
							prev_q[1] <= y0_q;
							total_q   <= root_q[F +: DW];
							idx_q     <= '0;
							active_q  <= root_q[F +: DW] != '0;
							pend_q    <= 1'b1;
							state_q   <= S_IDLE;
						end else begin
							state_q <= S_DGO;
						end
					end
				end
				S_T:   state_q <= S_MUL;
				S_MUL: state_q <= S_FIN;
				S_FIN: begin
					for (int j = 0; j < 2; j++) begin
						prev_q[j] <= pt[j];
						apt_q[j]  <= apt_q[j] + astep_q[j];
						bpt_q[j]  <= bpt_q[j] + bstep_q[j];
					end
					idx_q <= idx_nx;
					if (idx_nx >= total_q) active_q <= 1'b0;
					pend_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && pend_q) begin
			out_status_q  <= res_status_q;
			out_from_q    <= res_from_q;
			out_to_q      <= res_to_q;
			out_count_q   <= res_count_q;
			out_last_q    <= res_last_q;
		end
		if (q_pop) begin
			leg_q[0] <= e_ax;
			leg_q[1] <= e_ay;
			leg_q[2] <= e_bx;
			leg_q[3] <= e_by;
			x0_q <= e_x0;
			y0_q <= e_y0;
			x1_q <= e_x1;
			y1_q <= e_y1;
			if (e_op == OP_NEXT && !active_q) begin
				res_status_q <= ST_NONE;
				res_from_q   <= '{default: '0};
				res_to_q     <= '{default: '0};
				res_count_q  <= '0;
				res_last_q   <= 1'b0;
			end
		end
		case (state_q)
			S_SQ: begin
				for (int j = 0; j < 4; j++) begin
					sqr_q[j] <= (2 * DW)'(lmag[j]) * (2 * DW)'(lmag[j]);
				end
			end
			S_SUM: begin
				sqsh_q       <= sq;
				rem_q        <= '0;
				root_q       <= '0;
				it_q         <= '0;
				didx_q       <= DIV_INV;
				res_status_q <= ST_REJECT;
				res_from_q   <= '{default: '0};
				res_to_q     <= '{default: '0};
				res_count_q  <= '0;
				res_last_q   <= 1'b0;
			end
			S_ROOT: begin
				sqsh_q <= sqsh_q << 2;
				it_q   <= it_q + 1'b1;
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[R_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[R_W-2:0], 1'b0};
				end
			end
			S_DWT: begin
				if (div_done) begin
					didx_q       <= didx_q + 3'd1;
					res_status_q <= ST_ACCEPT;
					res_from_q   <= '{default: '0};
					res_to_q     <= '{default: '0};
					res_count_q  <= root_q[F +: DW];
					res_last_q   <= root_q[F +: DW] == '0;
				end
			end
			S_T: t_q <= T_W'(idx_q) * T_W'(inv_q);
			S_MUL: begin
				for (int j = 0; j < 2; j++) begin
					neg_q[j] <= dd[j][D_W-1];
					ph_q[j]  <= PH_W'(dmag[j][D_W-1:F]) * PH_W'(t_q);
					pl_q[j]  <= PL_W'(dmag[j][F-1:0]) * PL_W'(t_q);
				end
			end
			S_FIN: begin
				res_status_q <= ST_SEG;
				res_from_q   <= prev_q;
				res_to_q     <= pt;
				res_count_q  <= total_q;
				res_last_q   <= idx_nx >= total_q;
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_from_x = out_from_q[0];
	assign out_from_y = out_from_q[1];
	assign out_to_x   = out_to_q[0];
	assign out_to_y   = out_to_q[1];
	assign out_count  = out_count_q;
	assign out_last   = out_last_q;

endmodule

// ----- rtl/core/quadratic_bezier_line_segmenter_core.sv -----
`timescale 1ns / 1ps

// Quadratic Bezier flattener. Input transfers arrive on s_axis: tuser 0 loads
// a curve from the three control points in tdata, tuser 1 asks for the next
// line segment. Every input transfer gives exactly one result transfer on
// m_axis, in order; tuser carries its status and tlast marks the final
// segment of a curve (or an accepted curve that yields no segments).
// A next-segment request goes from the queue to the result register through
// queue pop, t multiply, partial products, and combine and round.
// Loading a curve is bound by the bit-serial square root and by five passes
// of the shared bit-serial divider; a zero-length curve is answered without them.
// An input register and a two-entry queue sit in front of the processing
// engine, so up to three further transfers are taken while a result waits.
// When m_axis_tready is low the result holds and the engine stops once its
// next result is ready. Reset clears all curve state: no curve is active.
module quadratic_bezier_line_segmenter_core #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_axis_tvalid,
	output logic                                       s_axis_tready,
	// x0, y0, x1, y1, x2, y2 from bit 0 up, zero-padded to bytes
	input  logic [((6*COORD_BITS+7)/8)*8-1:0]          s_axis_tdata,
	// op
	input  logic                                       s_axis_tuser,
	output logic                                       m_axis_tvalid,
	input  logic                                       m_axis_tready,
	// from_x, from_y, to_x, to_y, segment_count from bit 0 up, zero-padded
	output logic [((5*COORD_BITS+1+7)/8)*8-1:0]        m_axis_tdata,
	// status
	output qbls_pkg::status_t                          m_axis_tuser,
	output logic                                       m_axis_tlast
);
	import qbls_pkg::*;

	localparam int CW  = COORD_BITS;
	localparam int E_W = 8 * CW + 5;

	logic             f_valid, f_ready;
	logic [E_W-1:0]   f_entry;
	logic             q_valid, q_pop;
	logic [E_W-1:0]   q_entry;
	logic [CW-1:0]    from_x, from_y, to_x, to_y;
	logic [CW:0]      count;

	qbls_front #(
		.CW (CW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_pts    (s_axis_tdata[6*CW-1:0]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_entry (f_entry)
	);

	qbls_queue #(
		.W (E_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_entry),
		.out_valid (q_valid),
		.out_pop   (q_pop),
		.out_data  (q_entry)
	);

	qbls_back #(
		.CW (CW),
		.F  (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_entry    (q_entry),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_from_x (from_x),
		.out_from_y (from_y),
		.out_to_x   (to_x),
		.out_to_y   (to_y),
		.out_count  (count),
		.out_last   (m_axis_tlast)
	);

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[5*CW:0] = {count, to_y, to_x, from_y, from_x};
	end

`ifndef SYNTHESIS
	// Only segments and accepted curves may close a run.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		(m_axis_tuser == ST_SEG || m_axis_tuser == ST_ACCEPT))
		else $error("tlast on a reject or no-curve result");

	// Rejects and requests without a curve carry no coordinates or count.
	a_empty_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == ST_REJECT || m_axis_tuser == ST_NONE)) |->
		(m_axis_tdata == '0))
		else $error("non-zero payload on an empty result");

	// An accepted curve with no segments must be marked as the end of its run.
	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ST_ACCEPT && count == '0) |-> m_axis_tlast)
		else $error("empty curve not flagged with tlast");
`endif

endmodule
